@@ rtl/core/raster_font_glyph_unpack_core_assert.svh @@
// Assertion macros for the raster font glyph unpacker.
// Included by the RTL modules that carry concurrent checks; no other dependencies.
`ifndef RASTER_FONT_GLYPH_UNPACK_CORE_ASSERT_SVH
`define RASTER_FONT_GLYPH_UNPACK_CORE_ASSERT_SVH
`ifndef SYNTH
// Same-cycle implication, disabled while reset is asserted.
`define RFGU_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("rfgu assertion failed");
// Next-cycle implication, disabled while reset is asserted.
`define RFGU_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("rfgu assertion failed");
`else
`define RFGU_ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define RFGU_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

@@ rtl/core/rfgu_pkg.sv @@
// Shared types and constants for the raster font glyph unpacker.
// No dependencies; used by the channel interfaces and all RTL modules.
`timescale 1ns / 1ps
package rfgu_pkg;

  localparam int BYTE_W   = 8;
  localparam int STRIP_W  = 5;
  localparam int INDEX_W  = 16;
  localparam int CFG_IDX_W = 1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_GLYPH_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_PIXEL_HEIGHT = 1'b1;

  localparam logic [BYTE_W-1:0] GEOM_RESET = 8'd8;

  // Effective glyph geometry (zero register values already forced to one).
  typedef struct packed {
    logic [BYTE_W-1:0] width;
    logic [BYTE_W-1:0] height;
  } rfgu_geom_t;

  // One beat held in the input stage.
  typedef struct packed {
    logic               valid;
    logic [BYTE_W-1:0]  bitmap_byte;
    logic [BYTE_W-1:0]  row;
    logic [STRIP_W-1:0] strip;
    logic               last;
  } rfgu_beat_t;

endpackage

@@ rtl/core/rfgu_channels.sv @@
// Valid/ready channel interfaces for the glyph unpacker input and result beats.
// Depends on rfgu_pkg for field widths.
`timescale 1ns / 1ps
interface rfgu_in_if;
  import rfgu_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] bitmap_byte;

  modport source (output valid, output bitmap_byte, input ready);
  modport sink   (input valid, input bitmap_byte, output ready);
endinterface

interface rfgu_out_if;
  import rfgu_pkg::*;
  logic               valid;
  logic               ready;
  logic [BYTE_W-1:0]  row;
  logic [BYTE_W-1:0]  first_column;
  logic [BYTE_W-1:0]  pixels;
  logic [BYTE_W-1:0]  valid_mask;
  logic [INDEX_W-1:0] pixel_index;
  logic               last;

  modport source (output valid, output row, output first_column, output pixels,
                  output valid_mask, output pixel_index, output last, input ready);
  modport sink   (input valid, input row, input first_column, input pixels,
                  input valid_mask, input pixel_index, input last, output ready);
endinterface

@@ rtl/core/rfgu_ctrl.sv @@
// Input stage: configuration registers, row/strip counters and the input register.
// Depends on rfgu_pkg, rfgu_channels and the assertion macro header.
`timescale 1ns / 1ps
`include "raster_font_glyph_unpack_core_assert.svh"
module rfgu_ctrl (
  input  logic                              clk,
  input  logic                              rst_n,
  rfgu_in_if.sink                           in_ch,
  input  logic                              cfg_we,
  input  logic [rfgu_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  logic [rfgu_pkg::BYTE_W-1:0]       cfg_wdata,
  input  logic                              s2_ready,
  output rfgu_pkg::rfgu_beat_t              s1_beat,
  output rfgu_pkg::rfgu_geom_t              geom
);
  import rfgu_pkg::*;

  logic [BYTE_W-1:0]  glyph_width_r;
  logic [BYTE_W-1:0]  pixel_height_r;
  logic [BYTE_W-1:0]  row_cnt_r, row_cnt_nxt;
  logic [STRIP_W-1:0] strip_cnt_r, strip_cnt_nxt;
  rfgu_beat_t         s1_r, s1_nxt;
  logic [BYTE_W-1:0]  w_eff, h_eff;
  logic [STRIP_W-1:0] strips_m1;
  logic               row_end, last_now, in_ready, acc;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      glyph_width_r  <= GEOM_RESET;
      pixel_height_r <= GEOM_RESET;
    end else if (cfg_we) begin
      if (cfg_idx == REG_GLYPH_WIDTH) begin
        glyph_width_r <= cfg_wdata;
      end
      if (cfg_idx == REG_PIXEL_HEIGHT) begin
        pixel_height_r <= cfg_wdata;
      end
    end
  end

  // A zero register is treated as one.
  assign w_eff = (glyph_width_r == '0) ? BYTE_W'(1) : glyph_width_r;
  assign h_eff = (pixel_height_r == '0) ? BYTE_W'(1) : pixel_height_r;
  assign geom  = '{width: w_eff, height: h_eff};

  // Index of the last strip is (width - 1) / 8.
  assign strips_m1 = STRIP_W'((w_eff - BYTE_W'(1)) >> 3);
  assign row_end   = row_cnt_r >= (h_eff - BYTE_W'(1));
  assign last_now  = row_end && (strip_cnt_r >= strips_m1);

  // The stage takes a beat when it is empty or its beat moves on.
  assign in_ready    = !s1_r.valid || s2_ready;
  assign in_ch.ready = in_ready;
  assign acc         = in_ch.valid && in_ready;

  // Counters advance row first, then strip, and clear after the final byte.
  always_comb begin
    row_cnt_nxt   = row_cnt_r;
    strip_cnt_nxt = strip_cnt_r;
    if (acc) begin
      if (last_now) begin
        row_cnt_nxt   = '0;
        strip_cnt_nxt = '0;
      end else if (row_end) begin
        row_cnt_nxt   = '0;
        strip_cnt_nxt = strip_cnt_r + STRIP_W'(1);
      end else begin
        row_cnt_nxt = row_cnt_r + BYTE_W'(1);
      end
    end
  end

  // Input register with a snapshot of the counters.
  always_comb begin
    s1_nxt = s1_r;
    if (in_ready) begin
      s1_nxt.valid       = in_ch.valid;
      s1_nxt.bitmap_byte = in_ch.bitmap_byte;
      s1_nxt.row         = row_cnt_r;
      s1_nxt.strip       = strip_cnt_r;
      s1_nxt.last        = last_now;
    end
  end

  // Only the valid bit of the input register needs a reset value.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_cnt_r   <= '0;
      strip_cnt_r <= '0;
      s1_r.valid  <= 1'b0;
    end else begin
      row_cnt_r   <= row_cnt_nxt;
      strip_cnt_r <= strip_cnt_nxt;
      s1_r        <= s1_nxt;
    end
  end

  assign s1_beat = s1_r;

  // Checks on counter sequencing and stage holding.
  `RFGU_ASSERT_NEXT(a_last_clears, clk, rst_n, acc && last_now,
                    row_cnt_r == '0 && strip_cnt_r == '0)
  `RFGU_ASSERT_NEXT(a_row_steps, clk, rst_n, acc && !row_end,
                    row_cnt_r == BYTE_W'($past(row_cnt_r) + BYTE_W'(1)) && $stable(strip_cnt_r))
  `RFGU_ASSERT_NEXT(a_s1_holds, clk, rst_n, s1_r.valid && !s2_ready,
                    s1_r.valid && $stable(s1_r.bitmap_byte) && $stable(s1_r.row))

endmodule

@@ rtl/core/rfgu_calc.sv @@
// Result stage: clipping mask, pixel reordering, linear index and the result register.
// Depends on rfgu_pkg, rfgu_channels and the assertion macro header.
`timescale 1ns / 1ps
`include "raster_font_glyph_unpack_core_assert.svh"
module rfgu_calc (
  input  logic                 clk,
  input  logic                 rst_n,
  input  rfgu_pkg::rfgu_beat_t s1_beat,
  input  rfgu_pkg::rfgu_geom_t geom,
  output logic                 s2_ready,
  rfgu_out_if.source           out_ch
);
  import rfgu_pkg::*;

  logic               out_v_r;
  logic [BYTE_W-1:0]  row_r, col_r, pixels_r, mask_r;
  logic [INDEX_W-1:0] pixel_index_r;
  logic               last_r;
  logic [BYTE_W-1:0]  col, diff, mask, rev;
  logic [INDEX_W-1:0] prod, pidx;

  assign col  = {s1_beat.strip, 3'b000};
  assign diff = geom.width - col;

  // Mask of the columns inside the glyph width.
  always_comb begin
    if (col >= geom.width) begin
      mask = '0;
    end else if (diff >= BYTE_W'(8)) begin
      mask = '1;
    end else begin
      mask = (BYTE_W'(1) << diff[2:0]) - BYTE_W'(1);
    end
  end

  // The byte's MSB is the leftmost pixel, which becomes bit zero.
  always_comb begin
    for (int l = 0; l < BYTE_W; l++) begin
      rev[l] = s1_beat.bitmap_byte[BYTE_W-1-l];
    end
  end

  // Row-major index, kept modulo 2^16.
  assign prod = {8'd0, s1_beat.row} * {8'd0, geom.width};
  assign pidx = prod + {8'd0, col};

  // Result register; it loads whenever it is empty or being drained.
  assign s2_ready = !out_v_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (s2_ready) begin
      out_v_r <= s1_beat.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready) begin
      row_r         <= s1_beat.row;
      col_r         <= col;
      pixels_r      <= rev & mask;
      mask_r        <= mask;
      pixel_index_r <= pidx;
      last_r        <= s1_beat.last;
    end
  end

  assign out_ch.valid        = out_v_r;
  assign out_ch.row          = row_r;
  assign out_ch.first_column = col_r;
  assign out_ch.pixels       = pixels_r;
  assign out_ch.valid_mask   = mask_r;
  assign out_ch.pixel_index  = pixel_index_r;
  assign out_ch.last         = last_r;

  // Checks on the result register.
  `RFGU_ASSERT_NEXT(a_s2_loads, clk, rst_n, s1_beat.valid && s2_ready, out_v_r)
  `RFGU_ASSERT_NEXT(a_out_holds, clk, rst_n, out_v_r && !out_ch.ready,
                    out_v_r && $stable(pixel_index_r) && $stable(pixels_r))
  `RFGU_ASSERT_IMPL(a_pix_in_mask, clk, rst_n, out_v_r, (pixels_r & ~mask_r) == '0)

endmodule

@@ rtl/core/raster_font_glyph_unpack_core.sv @@
// Top level of the raster font glyph unpacker.
// Depends on rfgu_pkg, rfgu_channels, rfgu_ctrl and rfgu_calc.
`timescale 1ns / 1ps
// The unpacker takes one column-major glyph bitmap byte per beat and returns
// one row-major result beat for each, at a sustained rate of one byte per
// clock cycle while the output accepts results. The accepting edge loads the
// input register, where the row and strip counters are sampled and advanced,
// and a later edge loads the result register, which the mask, reordering
// and row*width+column multiply feed. While a result waits both registers
// hold, so a stalled output keeps at most two beats before input stalls.
// Write glyph_width and pixel_height only while no beats are in flight; a
// value of zero in either register is treated as one.
module raster_font_glyph_unpack_core (
  input  logic                           clk,
  input  logic                           rst_n,
  rfgu_in_if.sink                        in_ch,
  rfgu_out_if.source                     out_ch,
  input  logic                           cfg_we,
  input  logic [rfgu_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [rfgu_pkg::BYTE_W-1:0]    cfg_wdata
);
  import rfgu_pkg::*;

  rfgu_beat_t s1_beat;
  rfgu_geom_t geom;
  logic       s2_ready;

  // Counters, configuration and input register.
  rfgu_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .s2_ready  (s2_ready),
    .s1_beat   (s1_beat),
    .geom      (geom)
  );

  // Pixel computation and result register.
  rfgu_calc u_calc (
    .clk      (clk),
    .rst_n    (rst_n),
    .s1_beat  (s1_beat),
    .geom     (geom),
    .s2_ready (s2_ready),
    .out_ch   (out_ch)
  );

endmodule
